// ----- rtl/ordered_array_list_engine_core_assert.svh -----
// Assertion macros shared by the ordered array list engine RTL.
// Used by files that include this header; needs a clock i_clk and a reset i_rst_n in scope.
`ifndef ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OALE_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("oale: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("oale: next-cycle check failed");

`endif

// ----- rtl/oale_pkg.sv -----
// Shared types, codes and constants of the ordered array list engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package oale_pkg;

    // Default configuration of the list storage.
    localparam int unsigned OALE_DEPTH      = 64;
    localparam int unsigned OALE_DATA_WIDTH = 32;

    // Fixed widths of the item and result fields.
    localparam int unsigned OP_W     = 4;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned LENGTH_W = 7;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_APPEND     = 4'd0,
        OP_REPL_MATCH = 4'd1,
        OP_REPL_POS   = 4'd2,
        OP_INS_MATCH  = 4'd3,
        OP_INS_POS    = 4'd4,
        OP_DEL_MATCH  = 4'd5,
        OP_DEL_POS    = 4'd6,
        OP_COUNT      = 4'd7,
        OP_READ       = 4'd8
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // How the walk pointer is set up.
    typedef enum logic [1:0] {
        PM_SCAN,
        PM_SHR,
        PM_SHL
    } t_ptr_mode;

    // Where the hole (target index) comes from.
    typedef enum logic [1:0] {
        HS_END,
        HS_POS,
        HS_AT,
        HS_AFTER
    } t_hole_sel;

    // What the memory write port does this cycle.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_COMPACT,
        WR_SHR,
        WR_SHL,
        WR_PUT
    } t_wr_mode;

    // How the list length is updated this cycle.
    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_INC,
        LEN_DEC,
        LEN_WPTR
    } t_len_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      setup;
        t_ptr_mode ptr_mode;
        t_hole_sel hole_sel;
        logic      rd_run;
        logic      rd_hole;
        logic      scan;
        t_wr_mode  wr_mode;
        logic      fill_key;
        t_len_op   len_op;
        logic      result;
        t_status   res_status;
        logic      res_found;
        logic      res_count;
        logic      res_read;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_ok;
        logic ins_ok;
        logic match;
        logic walk_done;
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/oale_ctrl.sv -----
// Controller of the ordered array list engine: sequences each operation.
// Depends on oale_pkg; drives the datapath by command and reads its status.
`default_nettype none

module oale_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [oale_pkg::OP_W-1:0]   i_op,
    input  oale_pkg::t_stat             i_stat,
    output oale_pkg::t_cmd              o_cmd,
    output logic                        o_busy
);
    import oale_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_HOLE,
        S_SHR,
        S_SHL,
        S_PUT,
        S_RDQ,
        S_RESULT
    } t_state;

    t_state  r_state, n_state;
    t_op     r_op, n_op;
    t_status r_status, n_status;
    logic    r_busy, n_busy;
    logic    w_find_op;
    logic    w_insert_op;

    // Operations that stop at the first match, and those that grow the list.
    assign w_find_op   = (r_op == OP_REPL_MATCH) || (r_op == OP_INS_MATCH);
    assign w_insert_op = (r_op == OP_APPEND) || (r_op == OP_INS_MATCH) || (r_op == OP_INS_POS);

    // Next state and the commands of the current state.
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.res_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_op       = t_op'(i_op);
                    n_status   = ST_OK;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // Set the walk up for the operation, then check its preconditions.
                o_cmd.setup    = 1'b1;
                o_cmd.hole_sel = (r_op == OP_APPEND) ? HS_END : HS_POS;
                if ((r_op == OP_APPEND) || (r_op == OP_INS_POS)) begin
                    o_cmd.ptr_mode = PM_SHR;
                end else if (r_op == OP_DEL_POS) begin
                    o_cmd.ptr_mode = PM_SHL;
                end else begin
                    o_cmd.ptr_mode = PM_SCAN;
                end
                n_state = S_RESULT;
                case (r_op)
                    OP_APPEND: begin
                        if (i_stat.full) n_status = ST_FULL;
                        else n_state = S_SHR;
                    end
                    OP_REPL_MATCH, OP_COUNT: begin
                        n_state = S_SCAN;
                    end
                    OP_REPL_POS: begin
                        if (i_stat.pos_ok) n_state = S_PUT;
                        else n_status = ST_BADPOS;
                    end
                    OP_INS_MATCH: begin
                        if (i_stat.full) n_status = ST_FULL;
                        else n_state = S_SCAN;
                    end
                    OP_INS_POS: begin
                        if (i_stat.full) n_status = ST_FULL;
                        else if (i_stat.ins_ok) n_state = S_SHR;
                        else n_status = ST_BADPOS;
                    end
                    OP_DEL_MATCH: begin
                        if (i_stat.empty) n_status = ST_EMPTY;
                        else n_state = S_SCAN;
                    end
                    OP_DEL_POS: begin
                        if (i_stat.pos_ok) n_state = S_SHL;
                        else n_status = ST_BADPOS;
                    end
                    OP_READ: begin
                        if (i_stat.pos_ok) n_state = S_RDQ;
                        else n_status = ST_BADPOS;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                // Walk the list from the front; compaction writes as it goes.
                o_cmd.rd_run = 1'b1;
                o_cmd.scan   = 1'b1;
                if (r_op == OP_DEL_MATCH) o_cmd.wr_mode = WR_COMPACT;
                if (w_find_op && i_stat.match) begin
                    n_state = S_HOLE;
                end else if (i_stat.walk_done) begin
                    if (r_op == OP_DEL_MATCH) o_cmd.len_op = LEN_WPTR;
                    n_state = S_RESULT;
                end
            end
            S_HOLE: begin
                // Target the matched entry, or the slot right after it.
                o_cmd.setup    = 1'b1;
                o_cmd.ptr_mode = PM_SHR;
                o_cmd.hole_sel = (r_op == OP_INS_MATCH) ? HS_AFTER : HS_AT;
                n_state        = (r_op == OP_INS_MATCH) ? S_SHR : S_PUT;
            end
            S_SHR: begin
                o_cmd.rd_run  = 1'b1;
                o_cmd.wr_mode = WR_SHR;
                if (i_stat.walk_done) n_state = S_PUT;
            end
            S_SHL: begin
                o_cmd.rd_run  = 1'b1;
                o_cmd.wr_mode = WR_SHL;
                if (i_stat.walk_done) begin
                    o_cmd.len_op = LEN_DEC;
                    n_state      = S_RESULT;
                end
            end
            S_PUT: begin
                o_cmd.wr_mode  = WR_PUT;
                o_cmd.fill_key = (r_op == OP_APPEND);
                if (w_insert_op) o_cmd.len_op = LEN_INC;
                n_state = S_RESULT;
            end
            S_RDQ: begin
                o_cmd.rd_hole = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                o_cmd.result    = 1'b1;
                o_cmd.res_found = w_find_op || (r_op == OP_DEL_MATCH);
                o_cmd.res_count = (r_op == OP_COUNT);
                o_cmd.res_read  = (r_op == OP_READ) && (r_status == ST_OK);
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_APPEND;
            r_status <= ST_OK;
            r_busy   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_status <= n_status;
            r_busy   <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ----- rtl/oale_dpath.sv -----
// Datapath of the ordered array list engine: entry memory, length, walk pointers,
// comparator and result registers. Depends on oale_pkg and the assertion header.
`default_nettype none
`include "ordered_array_list_engine_core_assert.svh"

module oale_dpath #(
    parameter int unsigned DEPTH      = oale_pkg::OALE_DEPTH,
    parameter int unsigned DATA_WIDTH = oale_pkg::OALE_DATA_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [oale_pkg::VAL_W-1:0]   i_key_value,
    input  logic signed [oale_pkg::VAL_W-1:0]   i_new_value,
    input  logic [oale_pkg::POS_W-1:0]          i_position,
    input  oale_pkg::t_cmd                      i_cmd,
    output oale_pkg::t_stat                     o_stat,
    output logic                                o_done,
    output logic [oale_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_found,
    output logic [oale_pkg::COUNT_W-1:0]        o_match_count,
    output logic [oale_pkg::INDEX_W-1:0]        o_index,
    output logic signed [oale_pkg::VAL_W-1:0]   o_read_value,
    output logic [oale_pkg::LENGTH_W-1:0]       o_length
);
    import oale_pkg::*;

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned LW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = ((LW > POS_W) ? LW : POS_W) + 1;

    // Entry memory and its registered read port.
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [AW-1:0]         r_daddr;
    logic                  r_dv;

    // Latched item fields.
    logic [DATA_WIDTH-1:0] r_key;
    logic [DATA_WIDTH-1:0] r_nv;
    logic [POS_W-1:0]      r_pos;

    // List length and walk state.
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_ptr;
    logic [LW-1:0] r_rem;
    logic          r_down;
    logic [LW-1:0] r_hole;
    logic [AW-1:0] r_at;
    logic [LW-1:0] r_wptr;
    logic [LW-1:0] r_cnt;
    logic          r_found;

    // Result registers.
    logic                  r_done;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_found_out;
    logic [COUNT_W-1:0]    r_match_count;
    logic [INDEX_W-1:0]    r_index;
    logic signed [VAL_W-1:0] r_read_value;
    logic [LENGTH_W-1:0]   r_length;

    logic                  w_match;
    logic [LW-1:0]         w_pos_lw;
    logic [LW-1:0]         w_hole;
    logic [LW-1:0]         w_ptr_init;
    logic [LW-1:0]         w_rem_init;
    logic                  w_rd_go;
    logic                  w_rd_en;
    logic [AW-1:0]         w_raddr;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_compact_we;
    logic [CMPW-1:0]       w_pos_c;
    logic [CMPW-1:0]       w_len_c;

    // Position checks against the current length.
    assign w_pos_c  = CMPW'(r_pos);
    assign w_len_c  = CMPW'(r_len);
    assign w_pos_lw = LW'(r_pos);
    assign w_match  = r_dv && (r_rdata == r_key);

    assign o_stat.full      = (r_len == LW'(DEPTH));
    assign o_stat.empty     = (r_len == '0);
    assign o_stat.pos_ok    = (r_pos != '0) && (w_pos_c <= w_len_c);
    assign o_stat.ins_ok    = (r_pos != '0) && (w_pos_c <= (w_len_c + CMPW'(1)));
    assign o_stat.match     = w_match;
    assign o_stat.walk_done = (r_rem == '0) && !r_dv;

    // Target index of a put, and the starting point of the walk.
    always_comb begin
        case (i_cmd.hole_sel)
            HS_END:   w_hole = r_len;
            HS_POS:   w_hole = w_pos_lw - LW'(1);
            HS_AT:    w_hole = LW'(r_at);
            HS_AFTER: w_hole = LW'(r_at) + LW'(1);
            default:  w_hole = r_len;
        endcase
        case (i_cmd.ptr_mode)
            PM_SCAN: begin
                w_ptr_init = '0;
                w_rem_init = r_len;
            end
            PM_SHR: begin
                w_ptr_init = r_len - LW'(1);
                w_rem_init = r_len - w_hole;
            end
            PM_SHL: begin
                w_ptr_init = w_pos_lw;
                w_rem_init = r_len - w_pos_lw;
            end
            default: begin
                w_ptr_init = '0;
                w_rem_init = '0;
            end
        endcase
    end

    // Read port: the walk pointer, or the hole for a single read.
    assign w_rd_go = i_cmd.rd_run && (r_rem != '0);
    assign w_rd_en = w_rd_go || i_cmd.rd_hole;
    assign w_raddr = i_cmd.rd_hole ? r_hole[AW-1:0] : r_ptr[AW-1:0];

    // Write port: compaction, shifts by one in either direction, or a put.
    always_comb begin
        w_we         = 1'b0;
        w_waddr      = r_daddr;
        w_wdata      = r_rdata;
        w_compact_we = 1'b0;
        case (i_cmd.wr_mode)
            WR_COMPACT: begin
                w_compact_we = r_dv && (r_rdata != r_key);
                w_we         = w_compact_we;
                w_waddr      = r_wptr[AW-1:0];
            end
            WR_SHR: begin
                w_we    = r_dv;
                w_waddr = r_daddr + AW'(1);
            end
            WR_SHL: begin
                w_we    = r_dv;
                w_waddr = r_daddr - AW'(1);
            end
            WR_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_hole[AW-1:0];
                w_wdata = i_cmd.fill_key ? r_key : r_nv;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Length update.
    always_comb begin
        case (i_cmd.len_op)
            LEN_INC:  n_len = r_len + LW'(1);
            LEN_DEC:  n_len = r_len - LW'(1);
            LEN_WPTR: n_len = r_wptr;
            default:  n_len = r_len;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_dv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_dv   <= w_rd_en;
            r_done <= i_cmd.result;
        end
    end

    // Item fields, resized to the storage word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= DATA_WIDTH'(i_key_value);
            r_nv  <= DATA_WIDTH'(i_new_value);
            r_pos <= i_position;
        end
    end

    // Walk pointer and remaining count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_hole <= w_hole;
            r_ptr  <= w_ptr_init;
            r_rem  <= w_rem_init;
            r_down <= (i_cmd.ptr_mode == PM_SHR);
        end else if (w_rd_go) begin
            r_ptr <= r_down ? (r_ptr - LW'(1)) : (r_ptr + LW'(1));
            r_rem <= r_rem - LW'(1);
        end
    end

    // Match tracking and the compaction write pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found <= 1'b0;
            r_cnt   <= '0;
            r_wptr  <= '0;
        end else begin
            if (i_cmd.scan && w_match) begin
                r_cnt   <= r_cnt + LW'(1);
                r_found <= 1'b1;
                if (!r_found) r_at <= r_daddr;
            end
            if (w_compact_we) r_wptr <= r_wptr + LW'(1);
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_rd_en) begin
            r_rdata <= r_mem[w_raddr];
            r_daddr <= w_raddr;
        end
    end

    // Result registers, loaded once per item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_status      <= i_cmd.res_status;
            r_found_out   <= i_cmd.res_found && r_found;
            r_match_count <= i_cmd.res_count ? COUNT_W'(r_cnt) : '0;
            r_index       <= i_cmd.res_read ? INDEX_W'(r_hole) : '0;
            r_read_value  <= i_cmd.res_read ? VAL_W'($signed(r_rdata)) : '0;
            r_length      <= LENGTH_W'(r_len);
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found       = r_found_out;
    assign o_match_count = r_match_count;
    assign o_index       = r_index;
    assign o_read_value  = r_read_value;
    assign o_length      = r_length;

    // The length stays within the storage, and grows or shrinks only where it can.
    `OALE_ASSERT_HOLDS(a_len_in_range, 1'b1, r_len <= LW'(DEPTH))
    `OALE_ASSERT_HOLDS(a_no_overflow, i_cmd.len_op == LEN_INC, r_len < LW'(DEPTH))
    `OALE_ASSERT_HOLDS(a_no_underflow, i_cmd.len_op == LEN_DEC, r_len != '0)
    // Compaction never writes ahead of the entry being read.
    `OALE_ASSERT_HOLDS(a_compact_behind, (i_cmd.wr_mode == WR_COMPACT) && r_dv, LW'(r_daddr) >= r_wptr)
    // A result strobe lasts a single cycle.
    `OALE_ASSERT_NEXT(a_done_single, r_done, !r_done)

endmodule

`default_nettype wire

// ----- rtl/ordered_array_list_engine_core.sv -----
// Top level of the ordered array list engine: controller plus datapath.
// Depends on oale_pkg, oale_ctrl and oale_dpath.
//
// Usage: drive an item (i_op, i_key_value, i_new_value, i_position) with start high
// while busy is low; the item is taken at that clock edge. Exactly one result per item
// appears on the o_ result ports for one cycle, marked by o_done; it must be taken then.
// With L the list length before the operation: rejected items, unused codes, append,
// and replace or read at a position walk no entries; count and delete-matches walk
// all L entries; replace-match walks up to the first match (the search stops there);
// delete and insert at a position shift the tail only; insert after a match
// searches, then shifts right.
// One item is worked on at a time: a new item is not taken before the last result.
// The walk moves one entry per cycle, set by the single read port of the entry memory.
// busy drops in the cycle that shows o_done, so the next item can be taken then.
// Reset (synchronous, active low) empties the list; entries are not cleared and
// need no clearing pass since only entries below the length are ever read.
`default_nettype none

module ordered_array_list_engine_core #(
    parameter int unsigned DEPTH      = oale_pkg::OALE_DEPTH,
    parameter int unsigned DATA_WIDTH = oale_pkg::OALE_DATA_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [oale_pkg::OP_W-1:0]           i_op,
    input  logic signed [oale_pkg::VAL_W-1:0]   i_key_value,
    input  logic signed [oale_pkg::VAL_W-1:0]   i_new_value,
    input  logic [oale_pkg::POS_W-1:0]          i_position,
    output logic                                o_done,
    output logic [oale_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_found,
    output logic [oale_pkg::COUNT_W-1:0]        o_match_count,
    output logic [oale_pkg::INDEX_W-1:0]        o_index,
    output logic signed [oale_pkg::VAL_W-1:0]   o_read_value,
    output logic [oale_pkg::LENGTH_W-1:0]       o_length
);
    import oale_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Operation sequencer.
    oale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Storage, walk logic and result registers.
    oale_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key_value   (i_key_value),
        .i_new_value   (i_new_value),
        .i_position    (i_position),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_match_count (o_match_count),
        .o_index       (o_index),
        .o_read_value  (o_read_value),
        .o_length      (o_length)
    );

endmodule

`default_nettype wire
